// File: rtl/cqs_pkg.sv
`timescale 1ns / 1ps

package cqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 128;

    // Operation codes
    localparam logic [2:0] FUNC_PUT  = 3'd0;
    localparam logic [2:0] FUNC_TAKE = 3'd1;
    localparam logic [2:0] FUNC_PEEK = 3'd2;
    localparam logic [2:0] FUNC_SKIP = 3'd3;
    localparam logic [2:0] FUNC_FIND = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_in;
        logic [6:0] offset;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_out;
        logic       found;
        logic [6:0] used_count;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// File: rtl/cqs_cell.sv
`timescale 1ns / 1ps

module cqs_cell
    import cqs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_load_byte,
    input  logic [7:0] i_next_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.load) begin
            r_byte <= i_load_byte;
        end else if (i_ctl.shift) begin
            r_byte <= i_next_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: rtl/circular_byte_queue_with_search_core.sv
`timescale 1ns / 1ps

// Circular byte queue with put, take, peek, skip and find. The bytes live in a
// ring of QUEUE_DEPTH cells that rotates one place per cycle during seek, step
// and walk; only the head cell is ever read or written, and a pointer tracks
// which store index sits there. One word is worked at a time: an operation
// first rotates the ring until its target index (front, or back for put)
// reaches the head, then peek and skip rotate offset more places and find
// rotates once per occupied entry. Put has no overflow check and take has no
// empty check. The result register lets the next word be accepted while a
// result still waits.

module circular_byte_queue_with_search_core
    import cqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int UW = IW + 1;
    localparam int CW = (IW > 7) ? IW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,
        S_STEP,
        S_WALK,
        S_DONE
    } t_state;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] v);
        return (v == IW'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    t_state      r_state;
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_rd;
    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_tgt;
    logic [CW-1:0] r_cnt;
    logic [2:0]  r_func;
    logic [7:0]  r_data;
    logic [6:0]  r_offset;
    logic [7:0]  r_dout;
    logic        r_found;
    logic        r_out_valid;
    t_out_word   r_out;

    t_cell_ctl   w_ctl;
    logic [7:0]  w_byte [QUEUE_DEPTH];
    logic [UW-1:0] w_used;
    logic        w_at_tgt;
    logic        w_in_acc;

    assign w_at_tgt = (r_head == r_tgt);
    assign w_in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_wr >= r_rd) begin
            w_used = {1'b0, r_wr} - {1'b0, r_rd};
        end else begin
            w_used = {1'b0, r_wr} + UW'(QUEUE_DEPTH) - {1'b0, r_rd};
        end
    end

    always_comb begin
        w_ctl.load  = (r_state == S_SEEK) && w_at_tgt && (r_func == FUNC_PUT);
        w_ctl.shift = ((r_state == S_SEEK) && !w_at_tgt)
                   || ((r_state == S_STEP) && (r_cnt != '0))
                   || ((r_state == S_WALK) && (r_cnt != '0));
    end

    // Ring of cells: each takes its upper neighbor's byte on a shift
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_ctl w_cell_ctl;
        if (g == 0) begin : g_head
            assign w_cell_ctl = w_ctl;
        end else begin : g_body
            assign w_cell_ctl = '{shift: w_ctl.shift, load: 1'b0};
        end
        cqs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_cell_ctl),
            .i_load_byte (r_data),
            .i_next_byte (w_byte[(g + 1) % QUEUE_DEPTH]),
            .o_byte      (w_byte[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_rd        <= IW'(QUEUE_DEPTH / 2);
            r_wr        <= IW'(QUEUE_DEPTH / 2);
            r_tgt       <= '0;
            r_cnt       <= '0;
            r_func      <= FUNC_PUT;
            r_dout      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctl.shift) begin
                r_head <= f_inc(r_head);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_func   <= i_in_word.func;
                        r_data   <= i_in_word.data_in;
                        r_offset <= i_in_word.offset;
                        r_dout   <= '0;
                        r_found  <= 1'b0;
                        r_tgt    <= (i_in_word.func == FUNC_PUT) ? r_wr : r_rd;
                        if (i_in_word.func inside {FUNC_PUT, FUNC_TAKE, FUNC_PEEK,
                                                   FUNC_SKIP, FUNC_FIND}) begin
                            r_state <= S_SEEK;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SEEK: begin
                    if (w_at_tgt) begin
                        case (r_func)
                            FUNC_PUT: begin
                                r_wr    <= f_inc(r_wr);
                                r_state <= S_DONE;
                            end
                            FUNC_TAKE: begin
                                r_dout  <= w_byte[0];
                                r_rd    <= f_inc(r_rd);
                                r_state <= S_DONE;
                            end
                            FUNC_PEEK, FUNC_SKIP: begin
                                r_cnt   <= CW'(r_offset);
                                r_state <= S_STEP;
                            end
                            default: begin
                                r_cnt   <= CW'(w_used);
                                r_state <= S_WALK;
                            end
                        endcase
                    end
                end
                S_STEP: begin
                    if (r_cnt == '0) begin
                        if (r_func == FUNC_PEEK) begin
                            r_dout <= w_byte[0];
                        end else begin
                            r_rd <= r_head;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_WALK: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        if (w_byte[0] == r_data) begin
                            r_found <= 1'b1;
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    // Hold until the result register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.data_out   <= r_dout;
                        r_out.found      <= r_found;
                        r_out.used_count <= 7'(w_used);
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd < IW'(QUEUE_DEPTH - 1) || r_rd == IW'(QUEUE_DEPTH - 1))
        && (r_wr < IW'(QUEUE_DEPTH - 1) || r_wr == IW'(QUEUE_DEPTH - 1))
        && (r_head < IW'(QUEUE_DEPTH - 1) || r_head == IW'(QUEUE_DEPTH - 1)))
        else $error("queue index out of range");

    a_seek_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK && !w_at_tgt) |=> (r_head == f_inc($past(r_head))))
        else $error("ring head did not advance during seek");

    a_wr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SEEK) |=> $stable(r_wr))
        else $error("write index moved outside put");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted word did not start work");

endmodule

// File: tb/cqs_checker.sv
`timescale 1ns / 1ps

module cqs_checker
    import cqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    logic [7:0]  ring_bytes [QUEUE_DEPTH];
    int unsigned front_idx;
    int unsigned back_idx;
    t_out_word   expected_q [$];

    function automatic int unsigned fill_level();
        return (back_idx + QUEUE_DEPTH - front_idx) % QUEUE_DEPTH;
    endfunction

    // Apply one operation to the queue image and return the word it should produce.
    function automatic t_out_word queue_op(t_in_word w);
        t_out_word   r;
        int unsigned pos;
        int unsigned left;
        r = '0;
        case (w.func)
            FUNC_PUT: begin
                ring_bytes[back_idx] = w.data_in;
                back_idx = (back_idx + 1) % QUEUE_DEPTH;
            end
            FUNC_TAKE: begin
                r.data_out = ring_bytes[front_idx];
                front_idx = (front_idx + 1) % QUEUE_DEPTH;
            end
            FUNC_PEEK: begin
                r.data_out = ring_bytes[(front_idx + w.offset) % QUEUE_DEPTH];
            end
            FUNC_SKIP: begin
                front_idx = (front_idx + w.offset) % QUEUE_DEPTH;
            end
            FUNC_FIND: begin
                // walk only the occupied span, front up to but not including back
                pos = front_idx;
                left = fill_level();
                while (left != 0 && !r.found) begin
                    if (ring_bytes[pos] == w.data_in)
                        r.found = 1'b1;
                    pos = (pos + 1) % QUEUE_DEPTH;
                    left--;
                end
            end
            default: begin
            end
        endcase
        r.used_count = 7'(fill_level());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
                ring_bytes[k] = 8'h00;
            front_idx = QUEUE_DEPTH / 2;
            back_idx = QUEUE_DEPTH / 2;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(queue_op(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, i_out_word);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_word.data_out !== want.data_out) begin
                        $display("%0t: data_out expected %h got %h",
                                 $time, want.data_out, i_out_word.data_out);
                        o_fail_count++;
                    end
                    if (i_out_word.found !== want.found) begin
                        $display("%0t: found expected %b got %b",
                                 $time, want.found, i_out_word.found);
                        o_fail_count++;
                    end
                    if (i_out_word.used_count !== want.used_count) begin
                        $display("%0t: used_count expected %0d got %0d",
                                 $time, want.used_count, i_out_word.used_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cqs_pkg::*;

    localparam int         DEPTH            = DEFAULT_QUEUE_DEPTH;
    localparam int         RANDOM_WORDS     = 1200;
    localparam int         HOLD_CYCLES      = 400;
    localparam int         IDLE_LIMIT       = 4000;
    localparam int         DRAIN_CYCLES     = 2 * DEPTH + 40;
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    int        fail_count;
    int        pending;
    int        burst_left;
    int        idle_cycles = 0;
    bit        hold_req    = 1'b0;

    circular_byte_queue_with_search_core #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    cqs_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("circular_byte_queue_with_search_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall in modes of random length; a hold request stalls solid.
    initial begin
        t_stall_mode mode;
        int          mode_left;
        mode = STALL_NONE;
        mode_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic t_in_word mk(logic [2:0] f, logic [7:0] d, logic [6:0] o);
        t_in_word w;
        w.func = f;
        w.data_in = d;
        w.offset = o;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        pick = $urandom_range(0, 99);
        // small alphabet half the time so that find hits often
        w.data_in = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        w.offset = 7'($urandom);
        if (pick < 40) begin
            w.func = FUNC_PUT;
        end else if (pick < 55) begin
            w.func = FUNC_TAKE;
        end else if (pick < 68) begin
            w.func = FUNC_PEEK;
        end else if (pick < 76) begin
            w.func = FUNC_SKIP;
            if ($urandom_range(0, 3) != 0)
                w.offset = 7'($urandom_range(0, 3));
        end else if (pick < 95) begin
            w.func = FUNC_FIND;
        end else begin
            w.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        return w;
    endfunction

    // Offer one word at the falling edge, hold it until taken, then maybe go idle.
    task automatic send(input t_in_word w);
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    initial begin
        int sent;
        int run_len;
        bit held;
        bit drained;
        burst_left = 8;
        held = 1'b0;
        drained = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue, take from empty, skip all the way round
        send(mk(FUNC_FIND, 8'h00, 7'h00));
        send(mk(FUNC_PEEK, 8'h00, 7'h00));
        send(mk(FUNC_TAKE, 8'hFF, 7'h7F));
        send(mk(FUNC_SKIP, 8'h00, 7'h01));
        send(mk(FUNC_SKIP, 8'h00, 7'h7E));
        send(mk(FUNC_PUT, 8'h00, 7'h00));
        send(mk(FUNC_PUT, 8'hFF, 7'h7F));
        send(mk(FUNC_PUT, 8'hAA, 7'h00));
        send(mk(FUNC_PUT, 8'h55, 7'h7F));
        send(mk(FUNC_PUT, 8'h80, 7'h00));
        send(mk(FUNC_PUT, 8'h01, 7'h00));
        send(mk(FUNC_PEEK, 8'h00, 7'h00));
        send(mk(FUNC_PEEK, 8'hFF, 7'h7F));
        send(mk(FUNC_FIND, 8'hFF, 7'h00));
        send(mk(FUNC_FIND, 8'h7E, 7'h00));
        send(mk(FUNC_FIND, 8'h00, 7'h7F));
        send(mk(FUNC_TAKE, 8'h00, 7'h00));
        send(mk(FUNC_SKIP, 8'h00, 7'h00));
        send(mk(FUNC_SKIP, 8'h00, 7'h02));
        send(mk(FUNC_FIND, 8'hFF, 7'h00));
        send(mk(FUNC_TAKE, 8'h00, 7'h00));
        send(mk(FUNC_TAKE, 8'h00, 7'h00));
        send(mk(FUNC_TAKE, 8'h00, 7'h00));
        send(mk(FUNC_SPARE_FIRST, 8'hFF, 7'h7F));
        send(mk(FUNC_SPARE_FIRST + 3'd1, 8'h5A, 7'h2A));
        send(mk(FUNC_SPARE_LAST, 8'hA5, 7'h55));
        pause_until_drained();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if (!held && sent >= 300) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (!drained && sent >= 700) begin
                pause_until_drained();
                drained = 1'b1;
            end
            if ($urandom_range(0, 999) < 5) begin
                // run of puts, often long enough to wrap the whole store
                run_len = $urandom_range(0, 1) ? $urandom_range(126, 130)
                                               : $urandom_range(10, 60);
                repeat (run_len) begin
                    send(mk(FUNC_PUT, 8'($urandom), 7'($urandom)));
                    sent++;
                end
            end else begin
                send(random_word());
                sent++;
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("circular_byte_queue_with_search_core: match");
        else
            $display("circular_byte_queue_with_search_core: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/cqs_pkg.sv
rtl/cqs_cell.sv
rtl/circular_byte_queue_with_search_core.sv
tb/cqs_checker.sv
tb/tb.sv
